@@ hdl/bptc_pkg.sv @@
// shared widths, register indexes and constants for the barometer compensation block
package bptc_pkg;

    localparam int CAL_W     = 16;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRESS_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LATENCY   = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam t_cfg_idx REG_PRESSURE_OFFSET        = 3'd1;
    localparam t_cfg_idx REG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam t_cfg_idx REG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam t_cfg_idx REG_REFERENCE_TEMP         = 3'd4;
    localparam t_cfg_idx REG_TEMP_SLOPE             = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -19'sd129070;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 19'sd133070;

endpackage

@@ hdl/baro_pressure_temp_compensation.sv @@
// first-order barometer pressure and temperature compensation pipeline
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | i_start, o_busy           | i_raw_pressure, i_raw_temperature
//  result   | o_valid (one-cycle pulse) | o_temp_centideg, o_pressure_centimbar
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
//  one item may enter every cycle while o_busy is low
//  the pipeline has seven register stages: offset, three coefficient
//  products, scaling, split pressure product, product merge, offset subtract, final scale
//  synchronous active-low reset clears the stage valid bits and calibration words
//  o_busy is high only while reset is asserted; results cannot be held off
module baro_pressure_temp_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [bptc_pkg::RAW_W-1:0]          i_raw_pressure,
    input  logic [bptc_pkg::RAW_W-1:0]          i_raw_temperature,
    input  logic                                i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bptc_pkg::CAL_W-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [bptc_pkg::TEMP_W-1:0]  o_temp_centideg,
    output logic signed [bptc_pkg::PRESS_W-1:0] o_pressure_centimbar
);
    import bptc_pkg::*;

    logic [CAL_W-1:0] r_pressure_sensitivity;
    logic [CAL_W-1:0] r_pressure_offset;
    logic [CAL_W-1:0] r_sensitivity_temp_coeff;
    logic [CAL_W-1:0] r_offset_temp_coeff;
    logic [CAL_W-1:0] r_reference_temp;
    logic [CAL_W-1:0] r_temp_slope;

    logic [LATENCY-1:0] r_vld;
    logic               accept;

    logic [RAW_W-1:0]          r_s1_d1;
    logic signed [24:0]        r_s1_dt;
    logic signed [24:0]        n_s1_dt;

    logic [RAW_W-1:0]          r_s2_d1;
    logic signed [41:0]        r_s2_pt;
    logic signed [41:0]        r_s2_po;
    logic signed [41:0]        r_s2_ps;
    logic signed [41:0]        n_s2_pt;
    logic signed [41:0]        n_s2_po;
    logic signed [41:0]        n_s2_ps;

    logic signed [41:0]        s3_t_sum;
    logic signed [41:0]        s3_o_sum;
    logic signed [41:0]        s3_s_sum;
    logic [RAW_W-1:0]          r_s3_d1;
    logic signed [TEMP_W-1:0]  r_s3_temp;
    logic signed [35:0]        r_s3_off;
    logic signed [34:0]        r_s3_sens;
    logic signed [TEMP_W-1:0]  n_s3_temp;
    logic signed [35:0]        n_s3_off;
    logic signed [34:0]        n_s3_sens;

    logic signed [TEMP_W-1:0]  r_s4_temp;
    logic signed [35:0]        r_s4_off;
    logic [40:0]               r_s4_mlo;
    logic signed [42:0]        r_s4_mhi;
    logic [40:0]               n_s4_mlo;
    logic signed [42:0]        n_s4_mhi;

    logic signed [TEMP_W-1:0]  r_s5_temp;
    logic signed [35:0]        r_s5_off;
    logic signed [58:0]        r_s5_prod;
    logic signed [58:0]        n_s5_prod;

    logic signed [58:0]        s6_sum;
    logic signed [TEMP_W-1:0]  r_s6_temp;
    logic signed [38:0]        r_s6_x;
    logic signed [38:0]        n_s6_x;

    logic signed [38:0]        s7_sum;
    logic signed [TEMP_W-1:0]  r_temp;
    logic signed [PRESS_W-1:0] r_press;
    logic signed [PRESS_W-1:0] n_press;

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressure_sensitivity   <= '0;
            r_pressure_offset        <= '0;
            r_sensitivity_temp_coeff <= '0;
            r_offset_temp_coeff      <= '0;
            r_reference_temp         <= '0;
            r_temp_slope             <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PRESSURE_SENSITIVITY:   r_pressure_sensitivity   <= i_cfg_wdata;
                REG_PRESSURE_OFFSET:        r_pressure_offset        <= i_cfg_wdata;
                REG_SENSITIVITY_TEMP_COEFF: r_sensitivity_temp_coeff <= i_cfg_wdata;
                REG_OFFSET_TEMP_COEFF:      r_offset_temp_coeff      <= i_cfg_wdata;
                REG_REFERENCE_TEMP:         r_reference_temp         <= i_cfg_wdata;
                REG_TEMP_SLOPE:             r_temp_slope             <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    always_comb begin
        // dT
        n_s1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_reference_temp, 8'h00});

        // coefficient products
        n_s2_pt = 42'(r_s1_dt) * $signed(42'(r_temp_slope));
        n_s2_po = 42'(r_s1_dt) * $signed(42'(r_offset_temp_coeff));
        n_s2_ps = 42'(r_s1_dt) * $signed(42'(r_sensitivity_temp_coeff));

        // truncating divides and sums
        s3_t_sum  = r_s2_pt + (r_s2_pt[41] ? 42'sd8388607 : 42'sd0);
        s3_o_sum  = r_s2_po + (r_s2_po[41] ? 42'sd63 : 42'sd0);
        s3_s_sum  = r_s2_ps + (r_s2_ps[41] ? 42'sd127 : 42'sd0);
        n_s3_temp = $signed(s3_t_sum[41:23]) + TEMP_BASE;
        n_s3_off  = $signed({3'b000, r_pressure_offset, 17'h00000}) + $signed(s3_o_sum[41:6]);
        n_s3_sens = $signed({3'b000, r_pressure_sensitivity, 16'h0000})
                  + $signed(s3_s_sum[41:7]);

        // split pressure product
        n_s4_mlo = {17'h00000, r_s3_d1} * {24'h000000, r_s3_sens[16:0]};
        n_s4_mhi = 43'($signed({1'b0, r_s3_d1})) * 43'($signed(r_s3_sens[34:17]));

        // merge partial products
        n_s5_prod = ($signed({{16{r_s4_mhi[42]}}, r_s4_mhi}) <<< 17)
                  + $signed({18'h00000, r_s4_mlo});

        // divide by 2^21 and remove offset
        s6_sum = r_s5_prod + (r_s5_prod[58] ? 59'sd2097151 : 59'sd0);
        n_s6_x = $signed({s6_sum[58], s6_sum[58:21]}) - $signed({{3{r_s5_off[35]}}, r_s5_off});

        // divide by 2^15
        s7_sum  = r_s6_x + (r_s6_x[38] ? 39'sd32767 : 39'sd0);
        n_press = $signed({{8{s7_sum[38]}}, s7_sum[38:15]});
    end

    always_ff @(posedge i_clk) begin
        r_s1_d1   <= i_raw_pressure;
        r_s1_dt   <= n_s1_dt;

        r_s2_d1   <= r_s1_d1;
        r_s2_pt   <= n_s2_pt;
        r_s2_po   <= n_s2_po;
        r_s2_ps   <= n_s2_ps;

        r_s3_d1   <= r_s2_d1;
        r_s3_temp <= n_s3_temp;
        r_s3_off  <= n_s3_off;
        r_s3_sens <= n_s3_sens;

        r_s4_temp <= r_s3_temp;
        r_s4_off  <= r_s3_off;
        r_s4_mlo  <= n_s4_mlo;
        r_s4_mhi  <= n_s4_mhi;

        r_s5_temp <= r_s4_temp;
        r_s5_off  <= r_s4_off;
        r_s5_prod <= n_s5_prod;

        r_s6_temp <= r_s5_temp;
        r_s6_x    <= n_s6_x;

        r_temp    <= r_s6_temp;
        r_press   <= n_press;
    end

    assign o_valid              = r_vld[LATENCY-1];
    assign o_temp_centideg      = r_temp;
    assign o_pressure_centimbar = r_press;

endmodule

@@ hdl/bptc_checker.sv @@
// port-level checks for the barometer compensation block, with bind
module bptc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic                                o_valid,
    input logic signed [bptc_pkg::TEMP_W-1:0]  o_temp_centideg
);
    import bptc_pkg::*;

    a_idle_after_reset: assert property (@(posedge i_clk) i_rst_n |-> !o_busy)
        else $error("busy while out of reset");

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##7 o_valid)
        else $error("accepted item gave no result");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 7))
        else $error("result without accepted item");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temp_centideg >= TEMP_MIN) && (o_temp_centideg <= TEMP_MAX))
        else $error("temperature out of range");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_temp_centideg (o_temp_centideg)
);
